>>> rtl/core/lagged_fibonacci_uniform_rng_defines.svh
// Assertion helpers for the RTL back end (lfu_back).
`ifndef LAGGED_FIBONACCI_UNIFORM_RNG_DEFINES_SVH
`define LAGGED_FIBONACCI_UNIFORM_RNG_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define LFU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define LFU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lfu_pkg.sv
`default_nettype none

package lfu_pkg;

  localparam int LFU_TABLE_DEPTH = 97;
  localparam int LFU_QUEUE_DEPTH = 2;
  localparam int FRAC_BITS       = 24;
  localparam int SHORT_LAG_START = 33;

  localparam logic [23:0] SEQ_START = 24'd362436;
  localparam logic [23:0] SEQ_DEC   = 24'd7654321;
  localparam logic [23:0] SEQ_MOD   = 24'd16777213;
  localparam logic [23:0] SEQ_WRAP  = 24'd9122892;   // SEQ_MOD - SEQ_DEC

  localparam logic [14:0] SEED1_MAX     = 15'd31328;
  localparam logic [14:0] SEED2_MAX     = 15'd30081;
  localparam logic [14:0] SEED1_DEFAULT = 15'd1802;
  localparam logic [14:0] SEED2_DEFAULT = 15'd9373;

  localparam logic [7:0]  DIV_A  = 8'd177;
  localparam logic [7:0]  DIV_B  = 8'd169;
  localparam logic [7:0]  MOD_K  = 8'd179;
  localparam logic [13:0] L_MULT = 14'd53;

  // command classes
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // register indexes
  localparam logic REG_SEED_FIRST  = 1'b0;
  localparam logic REG_SEED_SECOND = 1'b1;

  typedef struct packed {
    logic        op;
    logic        range_error;
    logic [31:0] range_low;
    logic [32:0] span;
  } lfu_cmd_t;

  // Remainder of a value below 256*modulus, by eight conditional subtracts.
  function automatic logic [7:0] mod_small(input logic [14:0] value,
                                           input logic [7:0] modulus);
    logic [15:0] rem;
    logic [15:0] step;
    int          t;
    rem = {1'b0, value};
    for (t = 7; t >= 0; t--) begin
      step = 16'(modulus) << t;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[7:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lagged_fibonacci_uniform_rng.sv
// Lagged-Fibonacci uniform generator (lags 97 and 33, combined with a
// subtractive arithmetic sequence), all arithmetic in units of 2^-24. Each
// input transfer is either a draw, which returns the raw fraction and an
// integer in [range_low, range_high], or a reseed, which rebuilds the
// 97-entry table from the seed registers and returns zeros. Items enter a
// short command queue and are executed one at a time by the back end, so the
// input side keeps taking items while the queue has room, even when a result
// waits on out_stall. A draw steps the back end through the table read, the
// table update, the 25x33 range multiply split into two partial products, and
// the final add and clamp. A reseed runs the seed division and then 97 x 24
// bit steps, each through the states B0 to B4. The same reseed runs right after
// reset, during which queued items wait. Seed registers sit at byte address
// 0 (seed_first) and 4 (seed_second), should only be written while the block
// is idle, and are sampled when a reseed starts.
`default_nettype none

module lagged_fibonacci_uniform_rng #(
  parameter int TABLE_DEPTH = lfu_pkg::LFU_TABLE_DEPTH,
  parameter int QUEUE_DEPTH = lfu_pkg::LFU_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [24:0]             out_fraction,
  output logic signed [31:0]      out_int_value,
  output logic                    out_range_error
);

  import lfu_pkg::*;

  logic [14:0] seed_first_r;
  logic [14:0] seed_second_r;
  logic        cfg_write;
  logic        cmd_valid;
  logic        cmd_take;
  lfu_cmd_t    cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_first_r  <= SEED1_DEFAULT;
      seed_second_r <= SEED2_DEFAULT;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SEED_FIRST:  seed_first_r  <= pwdata[14:0];
        REG_SEED_SECOND: seed_second_r <= pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SEED_FIRST:  prdata = {17'b0, seed_first_r};
      REG_SEED_SECOND: prdata = {17'b0, seed_second_r};
      default:         prdata = '0;
    endcase
  end

  lfu_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take),
    .cmd           (cmd)
  );

  lfu_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .seed_first      (seed_first_r),
    .seed_second     (seed_second_r),
    .cmd_valid       (cmd_valid),
    .cmd_take        (cmd_take),
    .cmd             (cmd),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fraction    (out_fraction),
    .out_int_value   (out_int_value),
    .out_range_error (out_range_error)
  );

endmodule

`default_nettype wire

>>> rtl/core/lfu_ram.sv
`default_nettype none

module lfu_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 97
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_a <= mem_r[rd_addr_a];
    rd_data_b <= mem_r[rd_addr_b];
  end

endmodule

`default_nettype wire

>>> rtl/core/lfu_front.sv
`default_nettype none

module lfu_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_func,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  output logic                    cmd_valid,
  input  wire logic               cmd_take,
  output lfu_pkg::lfu_cmd_t       cmd
);

  import lfu_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  lfu_cmd_t      q_mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;
  logic [33:0]   diff;
  lfu_cmd_t      new_cmd;

  assign in_stall  = (count_r == CW'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_take && cmd_valid;

  // classify: span and order check are settled here, not in the back end
  always_comb begin
    diff = {{2{in_range_high[31]}}, in_range_high} - {{2{in_range_low[31]}}, in_range_low};
    new_cmd.op          = in_func ? OP_RESEED : OP_DRAW;
    new_cmd.range_error = diff[33];
    new_cmd.range_low   = in_range_low;
    new_cmd.span        = diff[32:0] + 33'd1;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lfu_back.sv
`default_nettype none

`include "lagged_fibonacci_uniform_rng_defines.svh"

module lfu_back #(
  parameter int TABLE_DEPTH = 97
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [14:0]        seed_first,
  input  wire logic [14:0]        seed_second,
  input  wire logic               cmd_valid,
  output logic                    cmd_take,
  input  wire lfu_pkg::lfu_cmd_t  cmd,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [24:0]             out_fraction,
  output logic signed [31:0]      out_int_value,
  output logic                    out_range_error
);

  import lfu_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int PTRW = $clog2(TABLE_DEPTH + 1);
  localparam int BCW  = $clog2(FRAC_BITS);
  localparam int FW   = FRAC_BITS + 1;
  localparam int XW   = FRAC_BITS + 2;
  localparam logic [XW-1:0] ONE_UNIT = XW'(1) << FRAC_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SEED = 4'd1;
  localparam logic [3:0] ST_DIV  = 4'd2;
  localparam logic [3:0] ST_B0   = 4'd3;
  localparam logic [3:0] ST_B1   = 4'd4;
  localparam logic [3:0] ST_B2   = 4'd5;
  localparam logic [3:0] ST_B3   = 4'd6;
  localparam logic [3:0] ST_B4   = 4'd7;
  localparam logic [3:0] ST_RD   = 4'd8;
  localparam logic [3:0] ST_X    = 4'd9;
  localparam logic [3:0] ST_MLO  = 4'd10;
  localparam logic [3:0] ST_MHI  = 4'd11;
  localparam logic [3:0] ST_SUM  = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  logic [3:0]      state_r, state_nxt;
  logic            from_cmd_r;
  lfu_cmd_t        cmd_r;
  logic [PTRW-1:0] long_ptr_r, short_ptr_r;
  logic [23:0]     carry_r;
  logic            out_valid_r;

  // reseed datapath
  logic [14:0]     rem_a_r, rem_b_r;
  logic [7:0]      quo_a_r, quo_b_r;
  logic [7:0]      i_r, j_r, k_r, l_r, r1_r;
  logic [14:0]     pij_r;
  logic [13:0]     pl_r;
  logic [23:0]     acc_r;
  logic [BCW-1:0]  bit_cnt_r;
  logic [AW-1:0]   n_r;

  // draw datapath
  logic [FW-1:0]   frac_r;
  logic [40:0]     pp_lo_r;
  logic [41:0]     pp_hi_r;
  logic [32:0]     q_r;

  logic [24:0]     out_fraction_r;
  logic [31:0]     out_int_value_r;
  logic            out_range_error_r;

  logic            seed_bad, div_a_go, div_b_go;
  logic [14:0]     seed_a, seed_b;
  logic            bit_last, n_last, out_free;
  logic [7:0]      m_c;
  logic [11:0]     lm_prod;
  logic [23:0]     acc_nxt;
  logic [FW-1:0]   rd_long, rd_short;
  logic [XW-1:0]   x_raw, x_fix, f_raw, f_fix;
  logic [FW-1:0]   x_c, f_c;
  logic [23:0]     carry_nxt;
  logic [PTRW-1:0] long_dec, short_dec;
  logic [57:0]     prod_sum;
  logic [32:0]     q_adj;
  logic [31:0]     int_c;
  logic            ram_we;
  logic [AW-1:0]   ram_wr_addr;
  logic [FW-1:0]   ram_wr_data;

  assign seed_bad = (seed_first > SEED1_MAX) || (seed_second > SEED2_MAX);
  assign seed_a   = seed_bad ? SEED1_DEFAULT : seed_first;
  assign seed_b   = seed_bad ? SEED2_DEFAULT : seed_second;
  assign div_a_go = (rem_a_r >= 15'(DIV_A));
  assign div_b_go = (rem_b_r >= 15'(DIV_B));

  assign bit_last = (bit_cnt_r == BCW'(FRAC_BITS - 1));
  assign n_last   = (n_r == AW'(TABLE_DEPTH - 1));
  assign m_c      = mod_small(pij_r, MOD_K);
  // (l*m) mod 64 >= 32 is bit 5 of the product; the low six bits suffice
  assign lm_prod  = 12'(l_r[5:0]) * 12'(k_r[5:0]);
  assign acc_nxt  = {acc_r[22:0], lm_prod[5]};

  assign x_raw     = {1'b0, rd_long} - {1'b0, rd_short};
  assign x_fix     = (x_raw[XW-1] || (x_raw == '0)) ? x_raw + ONE_UNIT : x_raw;
  assign x_c       = x_fix[FW-1:0];
  assign carry_nxt = (carry_r >= SEQ_DEC) ? carry_r - SEQ_DEC : carry_r + SEQ_WRAP;
  assign f_raw     = {1'b0, x_c} - XW'(carry_nxt);
  assign f_fix     = f_raw[XW-1] ? f_raw + ONE_UNIT : f_raw;
  assign f_c       = f_fix[FW-1:0];

  assign long_dec  = (long_ptr_r <= PTRW'(1)) ? PTRW'(TABLE_DEPTH) : long_ptr_r - PTRW'(1);
  assign short_dec = (short_ptr_r <= PTRW'(1)) ? PTRW'(TABLE_DEPTH) : short_ptr_r - PTRW'(1);

  assign prod_sum = {pp_hi_r, 16'b0} + {17'b0, pp_lo_r};
  // a fraction of exactly one lands on range_high + 1; pull it back by one
  assign q_adj    = q_r - {32'b0, (q_r == cmd_r.span)};
  assign int_c    = cmd_r.range_low + q_adj[31:0];

  assign out_free = !out_valid_r || !out_stall;
  assign cmd_take = (state_r == ST_IDLE) && cmd_valid;

  assign ram_we      = (state_r == ST_X) || ((state_r == ST_B4) && bit_last);
  assign ram_wr_addr = (state_r == ST_X) ? AW'(long_ptr_r - PTRW'(1)) : n_r;
  assign ram_wr_data = (state_r == ST_X) ? x_c : {1'b0, acc_nxt};

  lfu_ram #(
    .WIDTH (FW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_addr_a (AW'(long_ptr_r - PTRW'(1))),
    .rd_data_a (rd_long),
    .rd_addr_b (AW'(short_ptr_r - PTRW'(1))),
    .rd_data_b (rd_short)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.op == OP_RESEED) ? ST_SEED : ST_RD;
        end
      end
      ST_SEED: state_nxt = ST_DIV;
      ST_DIV: begin
        if (!div_a_go && !div_b_go) begin
          state_nxt = ST_B0;
        end
      end
      ST_B0:   state_nxt = ST_B1;
      ST_B1:   state_nxt = ST_B2;
      ST_B2:   state_nxt = ST_B3;
      ST_B3:   state_nxt = ST_B4;
      ST_B4: begin
        if (bit_last && n_last) begin
          state_nxt = from_cmd_r ? ST_DONE : ST_IDLE;
        end else begin
          state_nxt = ST_B0;
        end
      end
      ST_RD:   state_nxt = ST_X;
      ST_X:    state_nxt = ST_MLO;
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED;   // reset runs a reseed with the reset seeds
      from_cmd_r  <= 1'b0;
      long_ptr_r  <= PTRW'(TABLE_DEPTH);
      short_ptr_r <= PTRW'(SHORT_LAG_START);
      carry_r     <= SEQ_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd_take) begin
        from_cmd_r <= 1'b1;
      end
      if (state_r == ST_SEED) begin
        long_ptr_r  <= PTRW'(TABLE_DEPTH);
        short_ptr_r <= PTRW'(SHORT_LAG_START);
        carry_r     <= SEQ_START;
      end else if (state_r == ST_X) begin
        long_ptr_r  <= long_dec;
        short_ptr_r <= short_dec;
        carry_r     <= carry_nxt;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r <= cmd;
    end
    case (state_r)
      ST_SEED: begin
        rem_a_r <= seed_a;
        rem_b_r <= seed_b;
        quo_a_r <= '0;
        quo_b_r <= '0;
      end
      ST_DIV: begin
        if (div_a_go) begin
          rem_a_r <= rem_a_r - 15'(DIV_A);
          quo_a_r <= quo_a_r + 8'd1;
        end
        if (div_b_go) begin
          rem_b_r <= rem_b_r - 15'(DIV_B);
          quo_b_r <= quo_b_r + 8'd1;
        end
        i_r       <= quo_a_r + 8'd2;
        j_r       <= rem_a_r[7:0] + 8'd2;
        k_r       <= quo_b_r + 8'd1;
        l_r       <= rem_b_r[7:0];
        bit_cnt_r <= '0;
        n_r       <= '0;
      end
      ST_B0: begin
        pij_r <= 15'(16'(i_r) * 16'(j_r));
        pl_r  <= 14'(l_r) * L_MULT + 14'd1;
      end
      ST_B1: begin
        r1_r <= mod_small(pij_r, MOD_K);
        l_r  <= mod_small(15'(pl_r), DIV_B);
      end
      ST_B2: begin
        pij_r <= 15'(16'(r1_r) * 16'(k_r));
      end
      ST_B3: begin
        i_r <= j_r;
        j_r <= k_r;
        k_r <= m_c;
      end
      ST_B4: begin
        acc_r <= acc_nxt;
        if (bit_last) begin
          bit_cnt_r <= '0;
          n_r       <= n_r + AW'(1);
        end else begin
          bit_cnt_r <= bit_cnt_r + BCW'(1);
        end
      end
      ST_X: begin
        frac_r <= f_c;
      end
      ST_MLO: begin
        pp_lo_r <= 41'(frac_r) * 41'(cmd_r.span[15:0]);
      end
      ST_MHI: begin
        pp_hi_r <= 42'(frac_r) * 42'(cmd_r.span[32:16]);
      end
      ST_SUM: begin
        q_r <= prod_sum[56:24];
      end
      ST_DONE: begin
        if (out_free) begin
          if (cmd_r.op == OP_RESEED) begin
            out_fraction_r    <= '0;
            out_int_value_r   <= '0;
            out_range_error_r <= 1'b0;
          end else begin
            out_fraction_r    <= frac_r;
            out_int_value_r   <= cmd_r.range_error ? cmd_r.range_low : int_c;
            out_range_error_r <= cmd_r.range_error;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_fraction    = out_fraction_r;
  assign out_int_value   = out_int_value_r;
  assign out_range_error = out_range_error_r;

  `LFU_ASSERT_NOW(a_lag_gap, clk, rst_n, 1'b1,
    (8'(long_ptr_r) == 8'(short_ptr_r) + 8'(TABLE_DEPTH - SHORT_LAG_START)) || (8'(long_ptr_r) + 8'(SHORT_LAG_START) == 8'(short_ptr_r)),
    "long and short pointers lost their lag")
  `LFU_ASSERT_NOW(a_carry_bound, clk, rst_n, 1'b1, carry_r < SEQ_MOD,
    "carry sequence left its modulus")
  `LFU_ASSERT_NOW(a_frac_bound, clk, rst_n, state_r == ST_MLO, frac_r <= FW'(ONE_UNIT),
    "fraction above one")
  `LFU_ASSERT_NEXT(a_take_dispatch, clk, rst_n, cmd_take, (state_r == ST_SEED) || (state_r == ST_RD),
    "taken command did not start")

endmodule

`default_nettype wire

>>> sim/tb_top.sv
module tb_top;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
  localparam longint ONE_UNIT = longint'(1) << FRAC_BITS;

  typedef struct {
    logic              func;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    bit                 hold_for_drain;
  } rng_item_t;

  typedef struct packed {
    logic [24:0]        fraction;
    logic signed [31:0] int_value;
    logic               range_error;
  } rng_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = OP_DRAW;
  logic signed [31:0] in_range_low = '0;
  logic signed [31:0] in_range_high = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [24:0]        out_fraction;
  logic signed [31:0] out_int_value;
  logic               out_range_error;

  lagged_fibonacci_uniform_rng dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_range_low   (in_range_low),
    .in_range_high  (in_range_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_fraction   (out_fraction),
    .out_int_value  (out_int_value),
    .out_range_error(out_range_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // generator state mirror
  logic [24:0] lag_tab [0:LFU_TABLE_DEPTH-1];
  int unsigned long_ptr;
  int unsigned short_ptr;
  int unsigned seq_val;
  logic [14:0] seed_a_reg;
  logic [14:0] seed_b_reg;

  rng_item_t items_to_send[$];
  rng_out_t  rng_results_due[$];
  int        queued_count = 0;
  int        accepted_count = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      in_taken = 1'b0;

  function automatic void rebuild_table();
    int unsigned a, b, si, sj, sk, sl, m, acc;
    a = seed_a_reg;
    b = seed_b_reg;
    if (a > SEED1_MAX || b > SEED2_MAX) begin
      a = SEED1_DEFAULT;
      b = SEED2_DEFAULT;
    end
    si = (a / DIV_A) % DIV_A + 2;
    sj = (a % DIV_A) + 2;
    sk = (b / DIV_B) % 178 + 1;
    sl = b % DIV_B;
    for (int n = 0; n < LFU_TABLE_DEPTH; n++) begin
      acc = 0;
      for (int k = 0; k < FRAC_BITS; k++) begin
        m = (((si * sj) % MOD_K) * sk) % MOD_K;
        si = sj;
        sj = sk;
        sk = m;
        sl = (L_MULT * sl + 1) % DIV_B;
        acc = (acc << 1) | (((sl * m) % 64) >= 32 ? 1 : 0);
      end
      lag_tab[n] = acc[24:0];
    end
    seq_val = SEQ_START;
    long_ptr = LFU_TABLE_DEPTH;
    short_ptr = SHORT_LAG_START;
  endfunction

  // advances the generator by one draw, returns the fraction in 2^-24 units
  function automatic longint next_fraction();
    longint x, f;
    x = longint'(lag_tab[long_ptr-1]) - longint'(lag_tab[short_ptr-1]);
    if (x <= 0) x += ONE_UNIT;
    lag_tab[long_ptr-1] = x[24:0];
    long_ptr = (long_ptr <= 1) ? LFU_TABLE_DEPTH : long_ptr - 1;
    short_ptr = (short_ptr <= 1) ? LFU_TABLE_DEPTH : short_ptr - 1;
    if (seq_val >= SEQ_DEC) seq_val = seq_val - SEQ_DEC;
    else seq_val = seq_val + SEQ_MOD - SEQ_DEC;
    f = x - longint'(seq_val);
    if (f < 0) f += ONE_UNIT;
    return f;
  endfunction

  function automatic rng_out_t compute_rng_output(input logic func,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
    rng_out_t r;
    longint f, span, val;
    r = '0;
    if (func == OP_RESEED) begin
      rebuild_table();
      return r;
    end
    f = next_fraction();
    r.fraction = f[24:0];
    if (hi < lo) begin
      r.int_value = lo;
      r.range_error = 1'b1;
    end else begin
      span = longint'(hi) - longint'(lo) + 1;
      val = longint'(lo) + ((f * span) >> FRAC_BITS);
      // a fraction of exactly one would overshoot by one
      if (val > longint'(hi)) val = longint'(hi);
      r.int_value = val[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // monitor: check result transfers, predict on input transfers
  always @(posedge clk) begin : monitor
    rng_out_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rng_results_due.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = rng_results_due.pop_front();
          if (out_fraction !== want.fraction)
            report_mismatch($sformatf("fraction got %0d want %0d",
                                      out_fraction, want.fraction));
          if (out_int_value !== want.int_value)
            report_mismatch($sformatf("int_value got %0d want %0d",
                                      out_int_value, want.int_value));
          if (out_range_error !== want.range_error)
            report_mismatch($sformatf("range_error got %0b want %0b",
                                      out_range_error, want.range_error));
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        rng_results_due.push_back(compute_rng_output(in_func, in_range_low,
                                                     in_range_high));
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // driver: present items at the falling edge, hold until transferred
  always @(negedge clk) begin : driver
    rng_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(items_to_send[0].hold_for_drain && rng_results_due.size() != 0)) begin
        nxt = items_to_send.pop_front();
        in_valid <= 1'b1;
        in_func <= nxt.func;
        in_range_low <= nxt.lo;
        in_range_high <= nxt.hi;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic add_item(input logic func, input logic signed [31:0] lo,
                          input logic signed [31:0] hi, input bit hold = 1'b0);
    rng_item_t it;
    it.func = func;
    it.lo = lo;
    it.hi = hi;
    it.hold_for_drain = hold;
    items_to_send.push_back(it);
    queued_count++;
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || rng_results_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_seed(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SEED_FIRST) seed_a_reg = value[14:0];
    else seed_b_reg = value[14:0];
  endtask

  // upper bits are noise; the register keeps 15 bits
  function automatic logic [31:0] pick_seed(input logic [14:0] limit);
    logic [14:0] s;
    case ($urandom_range(9))
      0: s = 15'($urandom_range(32767, limit + 1));
      1: s = '0;
      2: s = limit;
      default: s = 15'($urandom_range(limit));
    endcase
    return ($urandom() & 32'hffff_8000) | 32'(s);
  endfunction

  task automatic pick_range(output logic signed [31:0] lo,
                            output logic signed [31:0] hi);
    longint t;
    lo = $urandom();
    case ($urandom_range(7))
      0, 1: hi = $urandom();
      2, 3: begin
        t = longint'(lo) + longint'($urandom_range(1000));
        hi = (t > longint'(INT_MAX)) ? INT_MAX : t[31:0];
      end
      4: begin
        lo = '0;
        hi = $urandom_range(255);
      end
      5: hi = lo;
      6: begin
        t = longint'(lo) - longint'($urandom_range(300, 1));
        hi = (t < longint'(INT_MIN)) ? INT_MAX : t[31:0];
      end
      default: begin
        lo = $urandom_range(1) ? INT_MIN : $urandom();
        hi = $urandom_range(1) ? INT_MAX : $urandom();
      end
    endcase
  endtask

  initial begin : stimulus
    logic signed [31:0] lo, hi;
    seed_a_reg = SEED1_DEFAULT;
    seed_b_reg = SEED2_DEFAULT;
    rebuild_table();
    send_idle_pct = 29;
    recv_idle_pct = 71;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default seeds: range extremes, single-value and inverted ranges, then a reseed
    add_item(OP_DRAW, INT_MIN, INT_MAX);
    add_item(OP_DRAW, '0, '0);
    add_item(OP_DRAW, INT_MIN, INT_MIN);
    add_item(OP_DRAW, INT_MAX, INT_MAX);
    add_item(OP_DRAW, '0, -32'sd1);
    add_item(OP_DRAW, INT_MAX, INT_MIN);
    add_item(OP_DRAW, '0, 32'sd1);
    add_item(OP_DRAW, -32'sd5, 32'sd5);
    add_item(OP_RESEED, INT_MAX, INT_MIN);
    add_item(OP_DRAW, 32'sd1, 32'sd6);
    wait_idle();

    // first seed out of range, upper write bits set
    write_seed(REG_SEED_FIRST, 32'hffff_0000 | 32'd31329);
    write_seed(REG_SEED_SECOND, 32'd100);
    add_item(OP_RESEED, '0, '0);
    add_item(OP_DRAW, INT_MIN, INT_MAX);
    wait_idle();

    // second seed one past its limit
    write_seed(REG_SEED_FIRST, 32'(SEED1_MAX));
    write_seed(REG_SEED_SECOND, 32'(SEED2_MAX) + 1);
    add_item(OP_RESEED, '0, '0);
    add_item(OP_DRAW, -32'sd100, 32'sd100);
    wait_idle();

    // both seeds at their highest valid values
    write_seed(REG_SEED_FIRST, 32'(SEED1_MAX));
    write_seed(REG_SEED_SECOND, 32'(SEED2_MAX));
    add_item(OP_RESEED, '0, '0);
    add_item(OP_DRAW, INT_MIN, INT_MAX);
    add_item(OP_DRAW, 32'sd10, -32'sd10);
    wait_idle();

    write_seed(REG_SEED_FIRST, '0);
    write_seed(REG_SEED_SECOND, '0);
    add_item(OP_RESEED, '0, '0);
    add_item(OP_DRAW, '0, 32'sd255);
    add_item(OP_DRAW, INT_MIN, INT_MAX);
    wait_idle();

    write_seed(REG_SEED_FIRST, 32'h7fff);
    write_seed(REG_SEED_SECOND, 32'h7fff);
    add_item(OP_RESEED, '0, '0);
    add_item(OP_DRAW, INT_MIN, INT_MAX);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 29; recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_seed(REG_SEED_FIRST, pick_seed(SEED1_MAX));
      write_seed(REG_SEED_SECOND, pick_seed(SEED2_MAX));
      add_item(OP_RESEED, $urandom(), $urandom());
      for (int n = 0; n < 245; n++) begin
        pick_range(lo, hi);
        if ($urandom_range(149) == 0) add_item(OP_RESEED, lo, hi);
        else add_item(OP_DRAW, lo, hi, phase == 0 && n == 120);
      end
      wait_idle();
    end

    repeat (30) @(negedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
